### hdl/wann_pkg.sv
// Shared types, constants and codes for the wrapped-angle nearest node search.
package wann_pkg;

    localparam int JOINTS   = 3;
    localparam int ANG_W    = 15;
    localparam int M_W      = 14;
    localparam int SQ_W     = 2 * M_W;
    localparam int DIST_W   = 29;
    localparam int IDX_W    = 10;
    localparam int CNT_W    = IDX_W + 1;
    localparam int DEPTH_W  = 10;
    localparam int LANES    = 4;
    localparam int LANE_W   = 2;
    localparam int ROW_W    = IDX_W - LANE_W;
    localparam int ROWS     = 1 << ROW_W;
    localparam int NODES    = 1 << IDX_W;
    localparam int PADDR_W  = 3;

    localparam logic [ANG_W-1:0]   FULL_TURN = ANG_W'(360 * 64);
    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam logic [1:0] RESET_ACTIVE_JOINTS = 2'd3;
    localparam logic       REG_ACTIVE_JOINTS   = 1'b0;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef logic [JOINTS-1:0][ANG_W-1:0] angle_vec_t;

    typedef struct packed {
        logic              valid;
        logic              same;
        logic [DIST_W-1:0] sum_sq;
    } lane_res_t;

    typedef struct packed {
        logic              dup;
        logic [IDX_W-1:0]  dup_idx;
        logic [IDX_W-1:0]  best_idx;
        logic [DIST_W-1:0] best_dist;
    } merge_res_t;

endpackage

### hdl/wrapped_angle_nearest_node.sv
// Top level: node table control, depth memory, configuration port and result register.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    kind, joint angles 0..2, parent index
//   m_        out        m_valid / m_ready    status, node index, distance, depth
//   APB       in         psel/penable/pready  active_joints at byte address 0
//
// An insert reads the parent's depth, then writes the new node. In a query over the
// stored nodes, four lanes scan one row of the node banks per cycle, then the lane
// pipeline and merge drain and the depth is read.
// Reset is synchronous and empties the table; no clearing pass is needed.
// One item is worked on at a time. A finished result waits in the output register
// while the next item is taken; a stalled sink holds off new items only once a
// second result is done behind the one still stuck there.
module wrapped_angle_nearest_node (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [wann_pkg::ANG_W-1:0]        s_joint_angle_0,
    input  logic [wann_pkg::ANG_W-1:0]        s_joint_angle_1,
    input  logic [wann_pkg::ANG_W-1:0]        s_joint_angle_2,
    input  logic [wann_pkg::IDX_W-1:0]        s_parent_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [wann_pkg::IDX_W-1:0]        m_node_index,
    output logic [wann_pkg::DIST_W-1:0]       m_distance_sq,
    output logic [wann_pkg::DEPTH_W-1:0]      m_node_depth,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wann_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_INS_RD   = 7'b0000010,
        S_INS_WR   = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_DRAIN    = 7'b0010000,
        S_DEPTH_RD = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    // Drain counter start: the drain ends as the merged result of the last row becomes final.
    localparam logic [2:0] DRAIN_LAST = 3'd4;

    state_t                                 state_reg;
    logic [1:0]                             active_joints_reg;
    logic [wann_pkg::CNT_W-1:0]             count_reg;
    wann_pkg::angle_vec_t                   q_reg, q_next;
    logic [wann_pkg::IDX_W-1:0]             slot_reg, par_reg;
    logic [wann_pkg::ROW_W-1:0]             row_reg;
    logic [2:0]                             drain_reg;
    wann_pkg::status_t                      res_status_reg;
    logic [wann_pkg::IDX_W-1:0]             res_index_reg;
    logic [wann_pkg::DIST_W-1:0]            res_dist_reg;
    logic [wann_pkg::DEPTH_W-1:0]           res_depth_reg;
    logic                                   mem_depth_reg;
    logic                                   m_valid_reg;
    logic [1:0]                             m_status_reg;
    logic [wann_pkg::IDX_W-1:0]             m_node_index_reg;
    logic [wann_pkg::DIST_W-1:0]            m_distance_sq_reg;
    logic [wann_pkg::DEPTH_W-1:0]           m_node_depth_reg;

    logic [wann_pkg::DEPTH_W-1:0]           depth_mem [0:wann_pkg::NODES-1];
    logic [wann_pkg::DEPTH_W-1:0]           depth_rdata_reg;
    logic [wann_pkg::IDX_W-1:0]             depth_rd_addr;
    logic                                   depth_rd_en;
    logic [wann_pkg::DEPTH_W-1:0]           depth_new;

    logic [1:0]                             nj;
    logic [wann_pkg::JOINTS-1:0]            joint_mask;
    logic [wann_pkg::IDX_W-1:0]             last_idx;
    logic                                   accept, cfg_write, out_free;
    logic [wann_pkg::LANES-1:0]             lane_wr_en, lane_rd_valid;
    wann_pkg::lane_res_t [wann_pkg::LANES-1:0] lane_res;
    wann_pkg::merge_res_t                   merge_res;

    assign nj = (active_joints_reg == 2'd0) ? 2'd1 : active_joints_reg;
    always_comb begin
        for (int j = 0; j < wann_pkg::JOINTS; j++) begin
            joint_mask[j] = (j < int'(nj));
        end
    end

    always_comb begin
        q_next[0] = s_joint_angle_0;
        q_next[1] = s_joint_angle_1;
        q_next[2] = s_joint_angle_2;
        for (int j = 0; j < wann_pkg::JOINTS; j++) begin
            if (!joint_mask[j]) begin
                q_next[j] = '0;
            end
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[wann_pkg::PADDR_W-1] == wann_pkg::REG_ACTIVE_JOINTS);
    assign out_free  = !m_valid_reg || m_ready;
    assign last_idx  = wann_pkg::IDX_W'(count_reg - 1'b1);

    always_comb begin
        for (int l = 0; l < wann_pkg::LANES; l++) begin
            lane_wr_en[l]    = (state_reg == S_INS_WR)
                               && (slot_reg[wann_pkg::LANE_W-1:0] == wann_pkg::LANE_W'(l));
            lane_rd_valid[l] = (state_reg == S_SCAN)
                               && ({row_reg, wann_pkg::LANE_W'(l)} <= last_idx);
        end
    end

    for (genvar l = 0; l < wann_pkg::LANES; l++) begin : g_lane
        wann_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .wr_en      (lane_wr_en[l]),
            .wr_row     (slot_reg[wann_pkg::IDX_W-1:wann_pkg::LANE_W]),
            .wr_angles  (q_reg),
            .rd_row     (row_reg),
            .rd_valid   (lane_rd_valid[l]),
            .query      (q_reg),
            .joint_mask (joint_mask),
            .res        (lane_res[l])
        );
    end

    wann_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (accept && (s_kind == wann_pkg::KIND_QUERY)),
        .lanes   (lane_res),
        .result  (merge_res)
    );

    // Depth memory: the parent's depth on insert, the winner's depth on query.
    assign depth_rd_en   = (state_reg == S_INS_RD) || (state_reg == S_DEPTH_RD);
    assign depth_rd_addr = (state_reg == S_INS_RD) ? par_reg
                         : (merge_res.dup ? merge_res.dup_idx : merge_res.best_idx);
    assign depth_new     = (count_reg == '0) ? '0
                         : (depth_rdata_reg == wann_pkg::DEPTH_MAX) ? wann_pkg::DEPTH_MAX
                         : depth_rdata_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (state_reg == S_INS_WR) begin
            depth_mem[slot_reg] <= depth_new;
        end
        if (depth_rd_en) begin
            depth_rdata_reg <= depth_mem[depth_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            active_joints_reg <= wann_pkg::RESET_ACTIVE_JOINTS;
            count_reg         <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_write) begin
                active_joints_reg <= pwdata[1:0];
            end
            // A new result loads in S_DONE; otherwise an accepted result clears here.
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        q_reg    <= q_next;
                        slot_reg <= count_reg[wann_pkg::IDX_W-1:0];
                        row_reg  <= '0;
                        if ((count_reg != '0)
                            && ({1'b0, s_parent_index} >= count_reg)) begin
                            par_reg <= last_idx;
                        end else begin
                            par_reg <= s_parent_index;
                        end
                        res_index_reg <= '0;
                        res_dist_reg  <= '0;
                        res_depth_reg <= '0;
                        mem_depth_reg <= 1'b0;
                        if (s_kind == wann_pkg::KIND_INSERT) begin
                            if (count_reg[wann_pkg::IDX_W]) begin
                                res_status_reg <= wann_pkg::ST_FULL;
                                state_reg      <= S_DONE;
                            end else begin
                                state_reg <= S_INS_RD;
                            end
                        end else begin
                            if (count_reg == '0) begin
                                res_status_reg <= wann_pkg::ST_EMPTY;
                                state_reg      <= S_DONE;
                            end else begin
                                state_reg <= S_SCAN;
                            end
                        end
                    end
                end
                S_INS_RD: begin
                    state_reg <= S_INS_WR;
                end
                S_INS_WR: begin
                    res_status_reg <= wann_pkg::ST_OK;
                    res_index_reg  <= slot_reg;
                    res_depth_reg  <= depth_new;
                    count_reg      <= count_reg + 1'b1;
                    state_reg      <= S_DONE;
                end
                S_SCAN: begin
                    row_reg <= row_reg + 1'b1;
                    if (row_reg == last_idx[wann_pkg::IDX_W-1:wann_pkg::LANE_W]) begin
                        drain_reg <= DRAIN_LAST;
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    drain_reg <= drain_reg - 1'b1;
                    if (drain_reg == '0) begin
                        state_reg <= S_DEPTH_RD;
                    end
                end
                S_DEPTH_RD: begin
                    mem_depth_reg <= 1'b1;
                    if (merge_res.dup) begin
                        res_status_reg <= wann_pkg::ST_DUP;
                        res_index_reg  <= merge_res.dup_idx;
                        res_dist_reg   <= '0;
                    end else begin
                        res_status_reg <= wann_pkg::ST_OK;
                        res_index_reg  <= merge_res.best_idx;
                        res_dist_reg   <= merge_res.best_dist;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        m_status_reg      <= res_status_reg;
                        m_node_index_reg  <= res_index_reg;
                        m_distance_sq_reg <= res_dist_reg;
                        m_node_depth_reg  <= mem_depth_reg ? depth_rdata_reg : res_depth_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_node_index  = m_node_index_reg;
    assign m_distance_sq = m_distance_sq_reg;
    assign m_node_depth  = m_node_depth_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[wann_pkg::PADDR_W-1] == wann_pkg::REG_ACTIVE_JOINTS)
                    ? {30'd0, active_joints_reg} : 32'd0;

endmodule

### hdl/wann_lane.sv
// One search lane: a bank of node angles and a four-stage distance pipeline.
module wann_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [wann_pkg::ROW_W-1:0]    wr_row,
    input  wann_pkg::angle_vec_t          wr_angles,
    input  logic [wann_pkg::ROW_W-1:0]    rd_row,
    input  logic                          rd_valid,
    input  wann_pkg::angle_vec_t          query,
    input  logic [wann_pkg::JOINTS-1:0]   joint_mask,
    output wann_pkg::lane_res_t           res
);

    wann_pkg::angle_vec_t                         mem [0:wann_pkg::ROWS-1];
    wann_pkg::angle_vec_t                         rdata_reg;
    logic                                         v1_reg, v2_reg, v3_reg;
    logic [wann_pkg::JOINTS-1:0][wann_pkg::M_W-1:0] m_reg, m_next;
    logic [wann_pkg::JOINTS-1:0]                  eq_reg, eq_next;
    logic [wann_pkg::JOINTS-1:0][wann_pkg::SQ_W-1:0] sq_reg;
    logic                                         same3_reg;
    logic [wann_pkg::DIST_W:0]                    sum;
    wann_pkg::lane_res_t                          res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_angles;
        end
        rdata_reg <= mem[rd_row];
    end

    // Wrapped difference per joint; the term is min(d, |d - full turn|).
    always_comb begin
        logic [wann_pkg::ANG_W-1:0] d;
        logic [wann_pkg::ANG_W-1:0] e;
        logic [wann_pkg::ANG_W-1:0] m;
        for (int j = 0; j < wann_pkg::JOINTS; j++) begin
            d = (rdata_reg[j] > query[j]) ? rdata_reg[j] - query[j] : query[j] - rdata_reg[j];
            e = (d <= wann_pkg::FULL_TURN) ? wann_pkg::FULL_TURN - d : d - wann_pkg::FULL_TURN;
            m = (d < e) ? d : e;
            if (joint_mask[j]) begin
                m_next[j]  = m[wann_pkg::M_W-1:0];
                eq_next[j] = (rdata_reg[j] == query[j]);
            end else begin
                m_next[j]  = '0;
                eq_next[j] = 1'b1;
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int j = 0; j < wann_pkg::JOINTS; j++) begin
            sum = sum + (wann_pkg::DIST_W + 1)'(sq_reg[j]);
        end
        res_next.valid  = v3_reg;
        res_next.same   = same3_reg;
        res_next.sum_sq = sum[wann_pkg::DIST_W] ? wann_pkg::DIST_MAX : sum[wann_pkg::DIST_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            res_reg.valid <= 1'b0;
        end else begin
            v1_reg        <= rd_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            res_reg.valid <= res_next.valid;
        end
        m_reg        <= m_next;
        eq_reg       <= eq_next;
        for (int j = 0; j < wann_pkg::JOINTS; j++) begin
            sq_reg[j] <= m_reg[j] * m_reg[j];
        end
        same3_reg      <= &eq_reg;
        res_reg.same   <= res_next.same;
        res_reg.sum_sq <= res_next.sum_sq;
    end

    assign res = res_reg;

endmodule

### hdl/wann_merge.sv
// Combines the lane results of each row, then folds them into the running best.
module wann_merge (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  clear,
    input  wann_pkg::lane_res_t [wann_pkg::LANES-1:0] lanes,
    output wann_pkg::merge_res_t                  result
);

    logic                            a_valid_reg;
    logic [wann_pkg::DIST_W-1:0]     a_dist_reg;
    logic [wann_pkg::LANE_W-1:0]     a_lane_reg;
    logic                            a_dup_reg;
    logic [wann_pkg::LANE_W-1:0]     a_dup_lane_reg;
    logic [wann_pkg::ROW_W-1:0]      row_reg;
    logic                            have_reg;
    wann_pkg::merge_res_t            best_reg;

    logic                            lo_valid, hi_valid, row_valid;
    logic [wann_pkg::DIST_W-1:0]     lo_dist, hi_dist, row_dist;
    logic [wann_pkg::LANE_W-1:0]     lo_lane, hi_lane, row_lane;
    logic                            row_dup;
    logic [wann_pkg::LANE_W-1:0]     row_dup_lane;
    logic [wann_pkg::IDX_W-1:0]      a_idx, a_dup_idx;

    // Two-level tree; the right side wins only when strictly closer,
    // so ties go to the lower node index.
    always_comb begin
        lo_valid = lanes[0].valid;
        lo_dist  = lanes[0].sum_sq;
        lo_lane  = wann_pkg::LANE_W'(0);
        if (lanes[1].valid && (!lanes[0].valid || lanes[1].sum_sq < lanes[0].sum_sq)) begin
            lo_valid = 1'b1;
            lo_dist  = lanes[1].sum_sq;
            lo_lane  = wann_pkg::LANE_W'(1);
        end
        hi_valid = lanes[2].valid;
        hi_dist  = lanes[2].sum_sq;
        hi_lane  = wann_pkg::LANE_W'(2);
        if (lanes[3].valid && (!lanes[2].valid || lanes[3].sum_sq < lanes[2].sum_sq)) begin
            hi_valid = 1'b1;
            hi_dist  = lanes[3].sum_sq;
            hi_lane  = wann_pkg::LANE_W'(3);
        end
        row_valid = lo_valid;
        row_dist  = lo_dist;
        row_lane  = lo_lane;
        if (hi_valid && (!lo_valid || hi_dist < lo_dist)) begin
            row_valid = 1'b1;
            row_dist  = hi_dist;
            row_lane  = hi_lane;
        end
        row_dup      = 1'b0;
        row_dup_lane = '0;
        for (int l = wann_pkg::LANES - 1; l >= 0; l--) begin
            if (lanes[l].valid && lanes[l].same) begin
                row_dup      = 1'b1;
                row_dup_lane = wann_pkg::LANE_W'(l);
            end
        end
    end

    assign a_idx     = {row_reg, a_lane_reg};
    assign a_dup_idx = {row_reg, a_dup_lane_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            row_reg      <= '0;
            have_reg     <= 1'b0;
            best_reg.dup <= 1'b0;
        end else begin
            a_valid_reg <= row_valid;
            if (clear) begin
                row_reg      <= '0;
                have_reg     <= 1'b0;
                best_reg.dup <= 1'b0;
            end else if (a_valid_reg) begin
                row_reg <= row_reg + 1'b1;
                if (!have_reg || a_dist_reg < best_reg.best_dist) begin
                    have_reg           <= 1'b1;
                    best_reg.best_dist <= a_dist_reg;
                    best_reg.best_idx  <= a_idx;
                end
                if (a_dup_reg && !best_reg.dup) begin
                    best_reg.dup     <= 1'b1;
                    best_reg.dup_idx <= a_dup_idx;
                end
            end
        end
        a_dist_reg     <= row_dist;
        a_lane_reg     <= row_lane;
        a_dup_reg      <= row_dup;
        a_dup_lane_reg <= row_dup_lane;
    end

    assign result = best_reg;

endmodule

### hdl/wann_checker.sv
// Port-level checker for the nearest node search, bound to the top level.
module wann_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [1:0]                    m_status,
    input logic [wann_pkg::IDX_W-1:0]    m_node_index,
    input logic [wann_pkg::DIST_W-1:0]   m_distance_sq,
    input logic [wann_pkg::DEPTH_W-1:0]  m_node_depth
);

    // Each item is worked on alone, so the input closes right after an accept.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input stayed ready after an item was accepted");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_node_index)
                               && $stable(m_distance_sq) && $stable(m_node_depth))
        else $error("result changed or dropped while stalled");

    a_empty_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == wann_pkg::ST_EMPTY || m_status == wann_pkg::ST_FULL)
        |-> m_node_index == '0 && m_distance_sq == '0 && m_node_depth == '0)
        else $error("empty or full result carries nonzero fields");

    a_dup_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == wann_pkg::ST_DUP |-> m_distance_sq == '0)
        else $error("duplicate result with nonzero distance");

endmodule

bind wrapped_angle_nearest_node wann_checker u_wann_checker (.*);
